@@ hw/rtl/nnfs_pkg.sv @@
// Shared types and constants of the nearest-neighbour frame scaler.
package nnfs_pkg;

  // Default sizes
  localparam int unsigned DEF_STORE_PIXELS = 16384;
  localparam int unsigned DEF_CHUNK_PIXELS = 80;
  localparam int unsigned DEF_MAX_DIM      = 1024;

  // Field widths
  localparam int unsigned DIMREG_W  = 11;
  localparam int unsigned STRIDE_W  = 15;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 15;
  localparam int unsigned INDEX_W   = 14;
  localparam int unsigned PIX_W     = 16;
  localparam int unsigned POS_W     = 10;

  // Register reset values
  localparam logic [DIMREG_W-1:0] RST_SRC_WIDTH  = DIMREG_W'(128);
  localparam logic [DIMREG_W-1:0] RST_SRC_HEIGHT = DIMREG_W'(128);
  localparam logic [STRIDE_W-1:0] RST_SRC_STRIDE = STRIDE_W'(128);
  localparam logic [DIMREG_W-1:0] RST_DST_WIDTH  = DIMREG_W'(320);
  localparam logic [DIMREG_W-1:0] RST_DST_HEIGHT = DIMREG_W'(240);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_SRC_STRIDE = 3'd2,
    CFG_DST_WIDTH  = 3'd3,
    CFG_DST_HEIGHT = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EMIT = 1'b1
  } cmd_e;

  typedef enum logic {
    STATUS_OK    = 1'b0,
    STATUS_EMPTY = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ROW,
    ST_DIV_ROW,
    ST_MUL_COL,
    ST_DIV_COL,
    ST_MUL_ADR,
    ST_MOD_ADR,
    ST_READ
  } state_e;

endpackage

@@ hw/rtl/nearest_neighbor_frame_scaler.sv @@
// Nearest-neighbour frame scaler: top level, sequencer and shared datapath.
//
// Usage: a request is taken when start is high and busy is low. A load
// request (cmd_i low) writes pixel_in_i to the frame store at load_index_i in
// that cycle and leaves busy low, so loads stream one per cycle. An emit
// request computes the next destination pixel in row-major order; busy stays
// high while the sequencer runs, then result_valid_o pulses for one cycle
// with the pixel and its position flags. The receiver cannot stall.
// An emit runs two restoring divisions on the one shared subtractor, one
// quotient bit per cycle. A division is skipped when that destination
// dimension is 1. A STORE_PIXELS that is not a power of two adds a modulo
// pass on the same subtractor. An empty source frame gives a status-only
// result in the cycle after the request, busy staying low.
// Configuration writes are always taken (cfg_ready_o high) and must come
// only while the block is idle.
// Reset clears the counters and loads the default registers; the frame store
// holds nothing defined until written.
module nearest_neighbor_frame_scaler #(
  parameter int unsigned STORE_PIXELS = nnfs_pkg::DEF_STORE_PIXELS,
  parameter int unsigned CHUNK_PIXELS = nnfs_pkg::DEF_CHUNK_PIXELS,
  parameter int unsigned MAX_DIM      = nnfs_pkg::DEF_MAX_DIM
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           cmd_i,
  input  logic [nnfs_pkg::INDEX_W-1:0]   load_index_i,
  input  logic [nnfs_pkg::PIX_W-1:0]     pixel_in_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [nnfs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [nnfs_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output logic                           result_valid_o,
  output logic [nnfs_pkg::PIX_W-1:0]     pixel_out_o,
  output logic [nnfs_pkg::POS_W-1:0]     dst_row_o,
  output logic [nnfs_pkg::POS_W-1:0]     dst_col_o,
  output logic [nnfs_pkg::POS_W-1:0]     chunk_start_col_o,
  output logic                           chunk_end_o,
  output logic                           frame_end_o,
  output logic                           status_o
);

  localparam int unsigned AW        = $clog2(STORE_PIXELS);
  localparam int unsigned CNT_W     = $clog2(MAX_DIM);
  localparam int unsigned DIM_W     = $clog2(MAX_DIM + 1);
  localparam int unsigned NUM_W     = CNT_W + DIM_W;
  localparam int unsigned MB_W      = (DIM_W > nnfs_pkg::STRIDE_W) ? DIM_W : nnfs_pkg::STRIDE_W;
  localparam int unsigned PROD_W    = CNT_W + MB_W;
  localparam int unsigned ADR_W     = CNT_W + nnfs_pkg::STRIDE_W + 1;
  localparam int unsigned MOD_STEPS = ADR_W - AW + 1;
  localparam bit          STORE_POW2 = (STORE_PIXELS == (1 << AW));
  localparam int unsigned U_W       = (ADR_W > DIM_W + 1) ? ADR_W : DIM_W + 1;
  localparam int unsigned STEP_MAX  = (NUM_W > MOD_STEPS) ? NUM_W : MOD_STEPS;
  localparam int unsigned STEP_W    = $clog2(STEP_MAX + 1);
  localparam int unsigned FILL_W    = $clog2(CHUNK_PIXELS + 1);
  localparam logic [ADR_W-1:0] MOD_B0 = ADR_W'(STORE_PIXELS << (MOD_STEPS - 1));

  // Configuration registers
  logic [nnfs_pkg::DIMREG_W-1:0] src_width_q, src_height_q, dst_width_q, dst_height_q;
  logic [nnfs_pkg::STRIDE_W-1:0] src_stride_q;

  // Sequencer and counters
  nnfs_pkg::state_e  state_q, state_d;
  logic [CNT_W-1:0]  row_q, col_q, base_q;
  logic [FILL_W-1:0] fill_q;

  // Datapath
  logic [NUM_W-1:0]  num_q;
  logic [DIM_W-1:0]  rem_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  srow_q;
  logic [ADR_W-1:0]  adr_q, modb_q;

  // Result registers
  logic                         res_valid_q;
  logic                         err_q;
  logic [nnfs_pkg::POS_W-1:0]   row_o_q, col_o_q, base_o_q;
  logic                         cend_q, fend_q;

  logic [DIM_W-1:0] sw, sh, dw, dh;
  logic [DIM_W-1:0] sw_m1, sh_m1, dw_m1, dh_m1;
  logic [DIM_W-1:0] row_p1, col_p1;
  logic             accept, load_we, emit_go, src_empty, out_of_frame;
  logic             last_col, last_row, cend;

  logic [CNT_W-1:0]  mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [U_W-1:0]    sub_a, sub_b;
  logic [U_W:0]      sub_diff;
  logic              sub_ge;

  logic             ram_re;
  logic [AW-1:0]    ram_addr;
  logic [nnfs_pkg::PIX_W-1:0] ram_rdata;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [nnfs_pkg::DIMREG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w == 32'd0) begin
      w = 32'd1;
    end else if (w > MAX_DIM) begin
      w = MAX_DIM;
    end
    return DIM_W'(w);
  endfunction

  assign sw    = clamp_dim(src_width_q);
  assign sh    = clamp_dim(src_height_q);
  assign dw    = clamp_dim(dst_width_q);
  assign dh    = clamp_dim(dst_height_q);
  assign sw_m1 = sw - DIM_W'(1);
  assign sh_m1 = sh - DIM_W'(1);
  assign dw_m1 = dw - DIM_W'(1);
  assign dh_m1 = dh - DIM_W'(1);

  assign busy         = (state_q != nnfs_pkg::ST_IDLE);
  assign accept       = start && !busy;
  assign load_we      = accept && (cmd_i == nnfs_pkg::CMD_LOAD) &&
                        (32'(load_index_i) < STORE_PIXELS);
  assign src_empty    = (src_width_q == '0) || (src_height_q == '0);
  assign emit_go      = accept && (cmd_i == nnfs_pkg::CMD_EMIT) && !src_empty;
  assign out_of_frame = (DIM_W'(row_q) >= dh) || (DIM_W'(col_q) >= dw);

  assign row_p1   = DIM_W'(row_q) + DIM_W'(1);
  assign col_p1   = DIM_W'(col_q) + DIM_W'(1);
  assign last_col = (col_p1 == dw);
  assign last_row = (row_p1 == dh);
  assign cend     = ({1'b0, fill_q} + (FILL_W + 1)'(1) >= (FILL_W + 1)'(CHUNK_PIXELS)) ||
                    last_col;

  // Shared multiplier: row and column scaling, then the row offset
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      nnfs_pkg::ST_MUL_ROW: begin
        mul_a = row_q;
        mul_b = MB_W'(sh_m1);
      end
      nnfs_pkg::ST_MUL_COL: begin
        mul_a = col_q;
        mul_b = MB_W'(sw_m1);
      end
      nnfs_pkg::ST_MUL_ADR: begin
        mul_a = srow_q;
        mul_b = MB_W'(src_stride_q);
      end
      default: begin
      end
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Shared compare-and-subtract unit: division steps and modulo reduction
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    unique case (state_q)
      nnfs_pkg::ST_DIV_ROW: begin
        sub_a = U_W'({rem_q, num_q[NUM_W-1]});
        sub_b = U_W'(dh_m1);
      end
      nnfs_pkg::ST_DIV_COL: begin
        sub_a = U_W'({rem_q, num_q[NUM_W-1]});
        sub_b = U_W'(dw_m1);
      end
      nnfs_pkg::ST_MOD_ADR: begin
        sub_a = U_W'(adr_q);
        sub_b = U_W'(modb_q);
      end
      default: begin
      end
    endcase
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[U_W];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      nnfs_pkg::ST_IDLE: begin
        if (emit_go) state_d = nnfs_pkg::ST_MUL_ROW;
      end
      nnfs_pkg::ST_MUL_ROW: begin
        state_d = (dh == DIM_W'(1)) ? nnfs_pkg::ST_MUL_COL : nnfs_pkg::ST_DIV_ROW;
      end
      nnfs_pkg::ST_DIV_ROW: begin
        if (step_q == '0) state_d = nnfs_pkg::ST_MUL_COL;
      end
      nnfs_pkg::ST_MUL_COL: begin
        state_d = (dw == DIM_W'(1)) ? nnfs_pkg::ST_MUL_ADR : nnfs_pkg::ST_DIV_COL;
      end
      nnfs_pkg::ST_DIV_COL: begin
        if (step_q == '0) state_d = nnfs_pkg::ST_MUL_ADR;
      end
      nnfs_pkg::ST_MUL_ADR: begin
        state_d = STORE_POW2 ? nnfs_pkg::ST_READ : nnfs_pkg::ST_MOD_ADR;
      end
      nnfs_pkg::ST_MOD_ADR: begin
        if (step_q == '0) state_d = nnfs_pkg::ST_READ;
      end
      nnfs_pkg::ST_READ: begin
        state_d = nnfs_pkg::ST_IDLE;
      end
      default: state_d = nnfs_pkg::ST_IDLE;
    endcase
  end

  // Control state, counters and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= nnfs_pkg::ST_IDLE;
      row_q        <= '0;
      col_q        <= '0;
      base_q       <= '0;
      fill_q       <= '0;
      res_valid_q  <= 1'b0;
      src_width_q  <= nnfs_pkg::RST_SRC_WIDTH;
      src_height_q <= nnfs_pkg::RST_SRC_HEIGHT;
      src_stride_q <= nnfs_pkg::RST_SRC_STRIDE;
      dst_width_q  <= nnfs_pkg::RST_DST_WIDTH;
      dst_height_q <= nnfs_pkg::RST_DST_HEIGHT;
    end else begin
      state_q     <= state_d;
      res_valid_q <= (accept && (cmd_i == nnfs_pkg::CMD_EMIT) && src_empty) ||
                     (state_q == nnfs_pkg::ST_READ);

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          nnfs_pkg::CFG_SRC_WIDTH:  src_width_q  <= nnfs_pkg::DIMREG_W'(cfg_data_i);
          nnfs_pkg::CFG_SRC_HEIGHT: src_height_q <= nnfs_pkg::DIMREG_W'(cfg_data_i);
          nnfs_pkg::CFG_SRC_STRIDE: src_stride_q <= cfg_data_i;
          nnfs_pkg::CFG_DST_WIDTH:  dst_width_q  <= nnfs_pkg::DIMREG_W'(cfg_data_i);
          nnfs_pkg::CFG_DST_HEIGHT: dst_height_q <= nnfs_pkg::DIMREG_W'(cfg_data_i);
          default: begin
          end
        endcase
      end

      // counters left outside the frame by a register change restart it
      if (emit_go && out_of_frame) begin
        row_q  <= '0;
        col_q  <= '0;
        base_q <= '0;
        fill_q <= '0;
      end

      if (state_q == nnfs_pkg::ST_READ) begin
        if (last_col) begin
          col_q  <= '0;
          fill_q <= '0;
          base_q <= '0;
          row_q  <= last_row ? '0 : CNT_W'(row_p1);
        end else begin
          col_q <= CNT_W'(col_p1);
          if (cend) begin
            fill_q <= '0;
            base_q <= CNT_W'(col_p1);
          end else begin
            fill_q <= fill_q + FILL_W'(1);
          end
        end
      end
    end
  end

  // Datapath and result payload
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      nnfs_pkg::ST_IDLE: begin
        if (accept && (cmd_i == nnfs_pkg::CMD_EMIT) && src_empty) begin
          err_q    <= nnfs_pkg::STATUS_EMPTY;
          row_o_q  <= '0;
          col_o_q  <= '0;
          base_o_q <= '0;
          cend_q   <= 1'b0;
          fend_q   <= 1'b0;
        end
      end
      nnfs_pkg::ST_MUL_ROW: begin
        num_q  <= (dh == DIM_W'(1)) ? '0 : NUM_W'(mul_p);
        rem_q  <= '0;
        step_q <= STEP_W'(NUM_W - 1);
      end
      nnfs_pkg::ST_MUL_COL: begin
        srow_q <= CNT_W'(num_q);
        num_q  <= (dw == DIM_W'(1)) ? '0 : NUM_W'(mul_p);
        rem_q  <= '0;
        step_q <= STEP_W'(NUM_W - 1);
      end
      nnfs_pkg::ST_DIV_ROW, nnfs_pkg::ST_DIV_COL: begin
        // restoring division, numerator shifts out as the quotient shifts in
        rem_q  <= sub_ge ? DIM_W'(sub_diff) : DIM_W'({rem_q, num_q[NUM_W-1]});
        num_q  <= {num_q[NUM_W-2:0], sub_ge};
        step_q <= step_q - STEP_W'(1);
      end
      nnfs_pkg::ST_MUL_ADR: begin
        adr_q  <= ADR_W'(mul_p) + ADR_W'(num_q[CNT_W-1:0]);
        modb_q <= MOD_B0;
        step_q <= STEP_W'(MOD_STEPS - 1);
      end
      nnfs_pkg::ST_MOD_ADR: begin
        if (sub_ge) adr_q <= ADR_W'(sub_diff);
        modb_q <= modb_q >> 1;
        step_q <= step_q - STEP_W'(1);
      end
      nnfs_pkg::ST_READ: begin
        err_q    <= nnfs_pkg::STATUS_OK;
        row_o_q  <= nnfs_pkg::POS_W'(row_q);
        col_o_q  <= nnfs_pkg::POS_W'(col_q);
        base_o_q <= nnfs_pkg::POS_W'(base_q);
        cend_q   <= cend;
        fend_q   <= last_col && last_row;
      end
      default: begin
      end
    endcase
  end

  assign ram_re   = (state_q == nnfs_pkg::ST_READ);
  assign ram_addr = ram_re ? adr_q[AW-1:0] : AW'(load_index_i);

  nnfs_ram #(
    .WIDTH (nnfs_pkg::PIX_W),
    .DEPTH (STORE_PIXELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (pixel_in_i),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o       = 1'b1;
  assign result_valid_o    = res_valid_q;
  assign pixel_out_o       = err_q ? '0 : ram_rdata;
  assign dst_row_o         = row_o_q;
  assign dst_col_o         = col_o_q;
  assign chunk_start_col_o = base_o_q;
  assign chunk_end_o       = cend_q;
  assign frame_end_o       = fend_q;
  assign status_o          = err_q;

`ifndef SYNTHESIS
  // the fetch always ends in a result strobe
  a_read_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == nnfs_pkg::ST_READ) |=> result_valid_o)
    else $error("read without result strobe");

  // while working, the counters lie inside the destination frame
  a_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != nnfs_pkg::ST_IDLE) |-> (DIM_W'(row_q) < dh) && (DIM_W'(col_q) < dw))
    else $error("counters outside frame during emit");

  // the sequencer starts only on an emit request with a valid source
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start && (cmd_i == nnfs_pkg::CMD_EMIT) && !src_empty))
    else $error("busy without emit request");
`endif

endmodule

@@ hw/rtl/nnfs_ram.sv @@
// Generic single-port RAM with registered read.
module nnfs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ tb/nnfs_pixel_checker.sv @@
// Checker for the frame scaler: tracks loads and registers, predicts each emitted pixel, compares.
module nnfs_pixel_checker
  import nnfs_pkg::*;
#(
  parameter int unsigned STORE_PIXELS = DEF_STORE_PIXELS,
  parameter int unsigned CHUNK_PIXELS = DEF_CHUNK_PIXELS,
  parameter int unsigned MAX_DIM      = DEF_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic                 cmd_i,
  input  logic [INDEX_W-1:0]   load_index_i,
  input  logic [PIX_W-1:0]     pixel_in_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  logic                 result_valid_i,
  input  logic [PIX_W-1:0]     pixel_out_i,
  input  logic [POS_W-1:0]     dst_row_i,
  input  logic [POS_W-1:0]     dst_col_i,
  input  logic [POS_W-1:0]     chunk_start_col_i,
  input  logic                 chunk_end_i,
  input  logic                 frame_end_i,
  input  logic                 status_i,
  output int                   pending_o,
  output int                   fails_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] chunk_col;
    logic             chunk_end;
    logic             frame_end;
    status_e          status;
  } scaled_px_t;

  logic [PIX_W-1:0]    frame_mem [STORE_PIXELS];
  logic [DIMREG_W-1:0] src_w, src_h, dst_w, dst_h;
  logic [STRIDE_W-1:0] stride;
  int unsigned         row_pos, col_pos, chunk_fill, chunk_col;
  scaled_px_t          want_q [$];
  int                  fail_tally = 0;

  assign fails_o = fail_tally;

  function automatic int unsigned fit_dim(int unsigned v);
    if (v < 1) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  // corner-aligned map; a single-pixel destination axis pins to source 0
  function automatic int unsigned scale_pos(int unsigned d, int unsigned slen,
                                            int unsigned dlen);
    if (dlen <= 1 || slen == 0) return 0;
    return d * (slen - 1) / (dlen - 1);
  endfunction

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    scaled_px_t        want;
    int unsigned       dw, dh, srow, scol;
    longint unsigned   addr;
    if (!rst_ni) begin
      src_w      = RST_SRC_WIDTH;
      src_h      = RST_SRC_HEIGHT;
      stride     = RST_SRC_STRIDE;
      dst_w      = RST_DST_WIDTH;
      dst_h      = RST_DST_HEIGHT;
      row_pos    = 0;
      col_pos    = 0;
      chunk_fill = 0;
      chunk_col  = 0;
      want_q.delete();
      pending_o <= 0;
    end else begin
      // pop before push: a strobe always belongs to an earlier request
      if (result_valid_i) begin
        if (want_q.size() == 0) begin
          $display("%0t ns: unexpected result, pixel %0h row %0d col %0d status %0d",
                   $time, pixel_out_i, dst_row_i, dst_col_i, status_i);
          fail_tally++;
        end else begin
          want = want_q.pop_front();
          check_field("pixel_out", want.pixel, pixel_out_i);
          check_field("dst_row", want.row, dst_row_i);
          check_field("dst_col", want.col, dst_col_i);
          check_field("chunk_start_col", want.chunk_col, chunk_start_col_i);
          check_field("chunk_end", want.chunk_end, chunk_end_i);
          check_field("frame_end", want.frame_end, frame_end_i);
          check_field("status", want.status, status_i);
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SRC_WIDTH:  src_w  = cfg_data_i[DIMREG_W-1:0];
          CFG_SRC_HEIGHT: src_h  = cfg_data_i[DIMREG_W-1:0];
          CFG_SRC_STRIDE: stride = cfg_data_i[STRIDE_W-1:0];
          CFG_DST_WIDTH:  dst_w  = cfg_data_i[DIMREG_W-1:0];
          CFG_DST_HEIGHT: dst_h  = cfg_data_i[DIMREG_W-1:0];
          default: ;
        endcase
      end

      if (start_i && !busy_i) begin
        if (cmd_i == CMD_LOAD) begin
          if (load_index_i < STORE_PIXELS) frame_mem[load_index_i] = pixel_in_i;
        end else if (src_w == 0 || src_h == 0) begin
          // empty source: status only, counters hold
          want        = '0;
          want.status = STATUS_EMPTY;
          want_q.push_back(want);
        end else begin
          dw = fit_dim(dst_w);
          dh = fit_dim(dst_h);
          if (row_pos >= dh || col_pos >= dw) begin
            row_pos    = 0;
            col_pos    = 0;
            chunk_fill = 0;
            chunk_col  = 0;
          end
          srow = scale_pos(row_pos, fit_dim(src_h), dh);
          scol = scale_pos(col_pos, fit_dim(src_w), dw);
          addr = (longint'(srow) * stride + scol) % STORE_PIXELS;

          want.pixel     = frame_mem[addr];
          want.row       = POS_W'(row_pos);
          want.col       = POS_W'(col_pos);
          want.chunk_col = POS_W'(chunk_col);
          want.chunk_end = (chunk_fill + 1 >= CHUNK_PIXELS) || (col_pos + 1 == dw);
          want.frame_end = (col_pos + 1 == dw) && (row_pos + 1 == dh);
          want.status    = STATUS_OK;
          want_q.push_back(want);

          if (col_pos + 1 == dw) begin
            col_pos    = 0;
            chunk_fill = 0;
            chunk_col  = 0;
            row_pos    = (row_pos + 1 == dh) ? 0 : row_pos + 1;
          end else begin
            col_pos++;
            if (want.chunk_end) begin
              chunk_fill = 0;
              chunk_col  = col_pos;
            end else begin
              chunk_fill++;
            end
          end
        end
      end
      pending_o <= want_q.size();
    end
  end

endmodule

@@ tb/tb_nearest_neighbor_frame_scaler.sv @@
// Testbench top for the frame scaler: clock, reset, stimulus and the verdict.
module tb_nearest_neighbor_frame_scaler;
  timeunit 1ns;
  timeprecision 1ps;
  import nnfs_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned RANDOM_ITEMS  = 750;
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 cmd_i          = CMD_LOAD;
  logic [INDEX_W-1:0]   load_index_i   = '0;
  logic [PIX_W-1:0]     pixel_in_i     = '0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CFG_DAT_W-1:0] cfg_data_i     = '0;
  logic                 result_valid_o;
  logic [PIX_W-1:0]     pixel_out_o;
  logic [POS_W-1:0]     dst_row_o;
  logic [POS_W-1:0]     dst_col_o;
  logic [POS_W-1:0]     chunk_start_col_o;
  logic                 chunk_end_o;
  logic                 frame_end_o;
  logic                 status_o;
  int                   pending, fails;
  int unsigned          cycles = 0;
  bit                   steady = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  nearest_neighbor_frame_scaler u_top (.*);

  nnfs_pixel_checker u_chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .cmd_i             (cmd_i),
    .load_index_i      (load_index_i),
    .pixel_in_i        (pixel_in_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_i       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .result_valid_i    (result_valid_o),
    .pixel_out_i       (pixel_out_o),
    .dst_row_i         (dst_row_o),
    .dst_col_i         (dst_col_o),
    .chunk_start_col_i (chunk_start_col_o),
    .chunk_end_i       (chunk_end_o),
    .frame_end_i       (frame_end_o),
    .status_i          (status_o),
    .pending_o         (pending),
    .fails_o           (fails)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // mostly back-to-back or short, now and then a long hold-off
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_src_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 9) return CFG_DAT_W'(DEF_MAX_DIM);
    if (r < 12) return CFG_DAT_W'($urandom);
    return CFG_DAT_W'($urandom_range(1, 40));
  endfunction

  function automatic logic [CFG_DAT_W-1:0] pick_dst_len(int unsigned hi);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 7) return CFG_DAT_W'(2047);
    if (r < 10) return CFG_DAT_W'(1);
    return CFG_DAT_W'($urandom_range(1, hi));
  endfunction

  // start stays high from one request to the next when there is no gap
  task automatic put_request(cmd_e c, logic [INDEX_W-1:0] idx, logic [PIX_W-1:0] pix,
                             int unsigned gap);
    if (gap > 0) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start        <= 1'b1;
    cmd_i        <= c;
    load_index_i <= idx;
    pixel_in_i   <= pix;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic run_emits(int unsigned n);
    repeat (n) put_request(CMD_EMIT, INDEX_W'($urandom), PIX_W'($urandom), pick_gap());
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_frame(logic [CFG_DAT_W-1:0] sw, logic [CFG_DAT_W-1:0] sh,
                           logic [CFG_DAT_W-1:0] sd, logic [CFG_DAT_W-1:0] dw,
                           logic [CFG_DAT_W-1:0] dh);
    write_reg(CFG_SRC_WIDTH, sw);
    write_reg(CFG_SRC_HEIGHT, sh);
    write_reg(CFG_SRC_STRIDE, sd);
    write_reg(CFG_DST_WIDTH, dw);
    write_reg(CFG_DST_HEIGHT, dh);
  endtask

  // drop start, wait for every result, then let a trailing load drain
  task automatic settle();
    @(negedge clk_i);
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned          items, len, r;
    bit                   wide;
    logic [CFG_DAT_W-1:0] sw, sh, sd, dw, dh;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // fill the whole store first so no fetch can land on an unwritten entry
    for (int i = 0; i < DEF_STORE_PIXELS; i++)
      put_request(CMD_LOAD, INDEX_W'(i), PIX_W'($urandom), pick_gap());

    // reset-value registers
    run_emits(3);

    // empty source in either axis, plus a write to an unmapped index
    settle();
    set_frame(0, 5, 5, 4, 4);
    write_reg(CFG_NONE, 15'h7FFF);
    run_emits(2);
    settle();
    write_reg(CFG_SRC_WIDTH, 5);
    write_reg(CFG_SRC_HEIGHT, 0);
    run_emits(1);

    // 1x1 destination: counters left outside the frame restart, every pixel ends it
    settle();
    set_frame(3, 2, 3, 1, 1);
    put_request(CMD_LOAD, '0, 16'hFFFF, pick_gap());
    run_emits(1);
    put_request(CMD_LOAD, 14'h3FFF, 16'h0000, pick_gap());
    run_emits(1);

    // zero destination dims read as one, oversized source saturates
    settle();
    set_frame(2047, 2047, 15'h7FFF, 0, 0);
    run_emits(1);

    // extreme stride and source: fetch address wraps the store
    settle();
    set_frame(DEF_MAX_DIM, 15'h7FFF, 15'h7FFF, 2, 2);
    run_emits(4);

    // zero stride, oversized destination
    settle();
    set_frame(4, 4, 0, 2047, 2047);
    run_emits(2);

    items = 0;
    while (items < RANDOM_ITEMS) begin
      settle();
      wide = (items == 0) || ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 19);
      if (r == 0) sd = '0;
      else if (r == 1) sd = 15'h7FFF;
      else if (r == 2) sd = CFG_DAT_W'($urandom);
      else sd = CFG_DAT_W'($urandom_range(1, 200));
      // rows wider than a chunk need long runs of emits to reach the chunk edge
      if (wide) begin
        sw  = CFG_DAT_W'($urandom_range(1, 300));
        sh  = CFG_DAT_W'($urandom_range(1, 40));
        dw  = CFG_DAT_W'($urandom_range(81, 130));
        dh  = CFG_DAT_W'($urandom_range(1, 2));
        len = $urandom_range(200, 280);
      end else begin
        sw  = pick_src_len();
        sh  = pick_src_len();
        dw  = pick_dst_len(12);
        dh  = pick_dst_len(6);
        len = $urandom_range(20, 60);
      end
      set_frame(sw, sh, sd, dw, dh);
      steady = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        if ($urandom_range(0, 99) < 85)
          put_request(CMD_EMIT, INDEX_W'($urandom), PIX_W'($urandom), pick_gap());
        else
          put_request(CMD_LOAD, INDEX_W'($urandom), PIX_W'($urandom), pick_gap());
        items++;
      end
    end

    settle();
    if (fails == 0 && pending == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
